FILE: src/tnme_pkg.sv
// Shared types and constants for the TCP NAPT mapping engine.
`default_nettype none
package tnme_pkg;
  localparam int SLOTS = 64;
  localparam int SLOT_W = 6;
  localparam int PORTS = 1024;
  localparam int PIDX_W = 10;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_DIR = 3'd1;
  localparam logic [2:0] ST_NON_TCP = 3'd2;
  localparam logic [2:0] ST_IN_MISS = 3'd3;
  localparam logic [2:0] ST_NO_RES = 3'd4;
  localparam logic [2:0] ST_TICK = 3'd5;

  localparam logic [1:0] REG_EXT_ADDR = 2'd0;
  localparam logic [1:0] REG_PORT_BASE = 2'd1;
  localparam logic [1:0] REG_PORT_COUNT = 2'd2;
  localparam logic [1:0] REG_IDLE = 2'd3;

  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_ACK = 8'h10;
  localparam logic [7:0] PROTO_TCP = 8'd6;

  typedef struct packed {
    logic        kind;
    logic [1:0]  direction;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  tcp_flags;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
  } item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input item
    logic clr_scan;    // reset scan index
    logic step_scan;   // advance scan index
    logic slot_rd;     // issue slot read at scan index
    logic sweep_eval;  // evaluate read slot for removal
    logic port_rd;     // issue port bitmap read
    logic port_clr;    // clear bitmap entry at port index
    logic alloc;       // write new mapping at free slot / port
    logic update;      // update hit slot
    logic tick_inc;    // advance clock
    logic free_wr;     // free port of removed slot
    logic set_out;     // load result register
    logic [2:0] code;  // status to load
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic bad_dir;
    logic non_tcp;
    logic inbound;
    logic slot_last;   // scan index at last slot
    logic port_last;   // port index at limit-1 or limit zero
    logic clr_last;    // bitmap clear at last index
    logic match;       // read slot matches the key
    logic hit;         // a hit was recorded
    logic free_slot;   // a free slot was recorded
    logic port_free;   // read port bit is clear and index below limit
    logic limit_zero;
  } stat_t;
endpackage
`default_nettype wire

FILE: src/tnme_datapath.sv
// Datapath: slot table memory, port bitmap memory, scan index, result register.
`default_nettype none
module tnme_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire tnme_pkg::item_t in_item,
  input  wire tnme_pkg::cmd_t cmd,
  output tnme_pkg::stat_t st,
  output logic [2:0] res_status,
  output logic [31:0] res_src_ip,
  output logic [31:0] res_dst_ip,
  output logic [15:0] res_src_port,
  output logic [15:0] res_dst_port,
  output logic [6:0] res_removed
);
  typedef struct packed {
    logic [31:0] remote_ip;
    logic [31:0] inner_ip;
    logic [15:0] inner_port;
    logic [9:0]  outer_idx;
    logic [1:0]  fin;
    logic [31:0] inner_seq;
    logic [31:0] outer_seq;
    logic [31:0] inner_ack;
    logic [31:0] outer_ack;
    logic [31:0] last_use;
  } slot_t;

  logic [31:0] ext_addr;
  logic [15:0] port_base;
  logic [10:0] port_count;
  logic [15:0] idle_limit;
  logic [31:0] tick_clock;

  tnme_pkg::item_t it;
  slot_t mem [tnme_pkg::SLOTS];
  logic [tnme_pkg::SLOTS-1:0] valid;
  slot_t rd;
  logic port_mem [tnme_pkg::PORTS];
  logic port_rd_bit;

  logic [tnme_pkg::SLOT_W:0] scan;      // one extra bit
  logic [tnme_pkg::SLOT_W-1:0] rd_idx;
  logic rd_pend;
  logic [tnme_pkg::PIDX_W-1:0] pidx;
  logic [tnme_pkg::PIDX_W-1:0] pidx_rd;
  logic hit;
  logic [tnme_pkg::SLOT_W-1:0] hit_slot;
  slot_t hit_data;
  logic free_found;
  logic [tnme_pkg::SLOT_W-1:0] free_slot;
  logic [6:0] removed;
  logic [10:0] limit;
  logic [15:0] rd_ext_port;
  logic match;
  logic idle_out;
  logic done_flow;
  logic remove;
  logic [31:0] age;

  always_comb begin
    limit = (port_count > 11'(tnme_pkg::PORTS)) ? 11'(tnme_pkg::PORTS) : port_count;
    rd_ext_port = port_base + {6'd0, rd.outer_idx};
    if (it.direction == 2'd0) begin
      match = valid[rd_idx] && rd.remote_ip == it.src_ip && rd_ext_port == it.dst_port
              && it.dst_ip == ext_addr;
    end else begin
      match = valid[rd_idx] && rd.remote_ip == it.dst_ip && rd.inner_ip == it.src_ip
              && rd.inner_port == it.src_port;
    end
    age = tick_clock - rd.last_use;
    idle_out = age > {16'd0, idle_limit};
    done_flow = rd.fin == 2'b11 && rd.inner_ack >= rd.outer_seq && rd.outer_ack >= rd.inner_seq;
    remove = valid[rd_idx] && (idle_out || done_flow);
  end

  always_comb begin
    st.is_tick = it.kind;
    st.bad_dir = it.direction[1];
    st.non_tcp = it.protocol != tnme_pkg::PROTO_TCP;
    st.inbound = it.direction == 2'd0;
    st.slot_last = scan[tnme_pkg::SLOT_W-1:0] == tnme_pkg::SLOT_W'(tnme_pkg::SLOTS - 1);
    st.port_last = {1'b0, pidx_rd} + 11'd1 >= limit;
    st.clr_last = pidx == tnme_pkg::PIDX_W'(tnme_pkg::PORTS - 1);
    st.match = rd_pend && match && !hit;
    st.hit = hit;
    st.free_slot = free_found;
    st.port_free = !port_rd_bit && {1'b0, pidx_rd} < limit;
    st.limit_zero = limit == 11'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_addr <= '0;
      port_base <= 16'd1024;
      port_count <= 11'd1024;
      idle_limit <= 16'd60;
    end else if (cfg_we) begin
      case (cfg_index)
        tnme_pkg::REG_EXT_ADDR: ext_addr <= cfg_data;
        tnme_pkg::REG_PORT_BASE: port_base <= cfg_data[15:0];
        tnme_pkg::REG_PORT_COUNT: port_count <= cfg_data[10:0];
        tnme_pkg::REG_IDLE: idle_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // slot memory: one read, one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.slot_rd) rd <= mem[scan[tnme_pkg::SLOT_W-1:0]];
    if (cmd.alloc) begin
      mem[free_slot] <= '{remote_ip: it.dst_ip, inner_ip: it.src_ip, inner_port: it.src_port,
        outer_idx: pidx_rd, fin: {1'b0, it.tcp_flags == tnme_pkg::FLAG_FIN},
        inner_seq: it.seq_number, outer_seq: '0,
        inner_ack: (it.tcp_flags == tnme_pkg::FLAG_ACK) ? it.ack_number : 32'd0,
        outer_ack: '0, last_use: tick_clock};
    end else if (cmd.update) begin
      if (it.direction == 2'd0) begin
        mem[hit_slot] <= '{remote_ip: hit_data.remote_ip, inner_ip: hit_data.inner_ip,
          inner_port: hit_data.inner_port, outer_idx: hit_data.outer_idx,
          fin: {it.tcp_flags == tnme_pkg::FLAG_FIN, hit_data.fin[0]},
          inner_seq: hit_data.inner_seq, outer_seq: it.seq_number,
          inner_ack: hit_data.inner_ack,
          outer_ack: (it.tcp_flags == tnme_pkg::FLAG_ACK) ? it.ack_number : hit_data.outer_ack,
          last_use: tick_clock};
      end else begin
        mem[hit_slot] <= '{remote_ip: hit_data.remote_ip, inner_ip: hit_data.inner_ip,
          inner_port: hit_data.inner_port, outer_idx: hit_data.outer_idx,
          fin: {hit_data.fin[1], it.tcp_flags == tnme_pkg::FLAG_FIN},
          inner_seq: it.seq_number, outer_seq: hit_data.outer_seq,
          inner_ack: (it.tcp_flags == tnme_pkg::FLAG_ACK) ? it.ack_number : hit_data.inner_ack,
          outer_ack: hit_data.outer_ack, last_use: tick_clock};
      end
    end
  end

  // port bitmap memory; cleared one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (cmd.port_rd) port_rd_bit <= port_mem[pidx];
    if (cmd.alloc) port_mem[pidx_rd] <= 1'b1;
    else if (cmd.free_wr && rd_pend && remove) port_mem[rd.outer_idx] <= 1'b0;
    else if (cmd.port_clr) port_mem[pidx] <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) it <= in_item;
    if (cmd.port_rd) pidx_rd <= pidx;
    if (rst) begin
      valid <= '0;
      tick_clock <= '0;
      scan <= '0;
      rd_pend <= 1'b0;
      hit <= 1'b0;
      free_found <= 1'b0;
      pidx <= '0;
      removed <= '0;
    end else begin
      rd_pend <= cmd.slot_rd;
      if (cmd.slot_rd) rd_idx <= scan[tnme_pkg::SLOT_W-1:0];
      if (cmd.tick_inc) tick_clock <= tick_clock + 32'd1;
      if (cmd.clr_scan) begin
        scan <= '0;
        hit <= 1'b0;
        free_found <= 1'b0;
        pidx <= '0;
        removed <= '0;
      end else if (cmd.step_scan) begin
        scan <= scan + 1'b1;
      end
      if (cmd.port_rd || cmd.port_clr) pidx <= pidx + 1'b1;
      if (rd_pend && !cmd.sweep_eval) begin
        if (match && !hit) begin
          hit <= 1'b1;
          hit_slot <= rd_idx;
          hit_data <= rd;
        end
        if (!valid[rd_idx] && !free_found) begin
          free_found <= 1'b1;
          free_slot <= rd_idx;
        end
      end
      if (cmd.sweep_eval && rd_pend && remove) begin
        valid[rd_idx] <= 1'b0;
        removed <= removed + 7'd1;
      end
      if (cmd.alloc) valid[free_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_out) begin
      res_status <= cmd.code;
      res_src_ip <= '0;
      res_dst_ip <= '0;
      res_src_port <= '0;
      res_dst_port <= '0;
      res_removed <= '0;
      if (cmd.code == tnme_pkg::ST_TICK) begin
        res_removed <= removed;
      end else if (cmd.code == tnme_pkg::ST_OK) begin
        if (it.direction == 2'd0) begin
          res_src_ip <= it.src_ip;
          res_dst_ip <= hit_data.inner_ip;
          res_src_port <= it.src_port;
          res_dst_port <= hit_data.inner_port;
        end else begin
          res_src_ip <= ext_addr;
          res_dst_ip <= it.dst_ip;
          res_src_port <= port_base + {6'd0, hit ? hit_data.outer_idx : pidx_rd};
          res_dst_port <= it.dst_port;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/tnme_ctrl.sv
// Controller: sequences lookup, allocation, sweep and result hand-off.
`default_nettype none
module tnme_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire tnme_pkg::stat_t st,
  output tnme_pkg::cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_SCAN_END = 4'd3;
  localparam logic [3:0] S_CLEAR = 4'd4;
  localparam logic [3:0] S_PORT_CHK = 4'd5;
  localparam logic [3:0] S_SWEEP = 4'd6;
  localparam logic [3:0] S_SWEEP_END = 4'd7;
  localparam logic [3:0] S_FREE = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;

  logic [3:0] state, state_next;
  logic out_full, out_full_next;
  logic last_rd, last_rd_next;
  logic out_busy;

  // result register still held by the receiver at the next edge
  assign out_busy = out_full && !out_ready;
  assign in_ready = state == S_IDLE;
  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    cmd = '0;
    out_full_next = out_full && !out_ready;
    last_rd_next = last_rd;
    case (state)
      S_CLEAR: begin
        cmd.port_clr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          cmd.clr_scan = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        last_rd_next = 1'b0;
        if (st.is_tick) begin
          cmd.tick_inc = 1'b1;
          state_next = S_SWEEP;
        end else if (st.bad_dir || st.non_tcp) begin
          if (!out_busy) begin
            cmd.set_out = 1'b1;
            cmd.code = st.bad_dir ? tnme_pkg::ST_BAD_DIR : tnme_pkg::ST_NON_TCP;
            state_next = S_OUT;
          end
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.slot_rd = 1'b1;
        cmd.step_scan = 1'b1;
        if (st.slot_last) state_next = S_SCAN_END;
      end
      S_SCAN_END: begin
        // last read result lands this cycle; decide next cycle
        if (!last_rd) begin
          last_rd_next = 1'b1;
        end else if (st.hit) begin
          if (!out_busy) begin
            cmd.update = 1'b1;
            cmd.set_out = 1'b1; cmd.code = tnme_pkg::ST_OK; state_next = S_OUT;
          end
        end else if (st.inbound) begin
          if (!out_busy) begin
            cmd.set_out = 1'b1; cmd.code = tnme_pkg::ST_IN_MISS; state_next = S_OUT;
          end
        end else if (!st.free_slot || st.limit_zero) begin
          if (!out_busy) begin
            cmd.set_out = 1'b1; cmd.code = tnme_pkg::ST_NO_RES; state_next = S_OUT;
          end
        end else begin
          cmd.port_rd = 1'b1;
          state_next = S_PORT_CHK;
        end
      end
      S_PORT_CHK: begin
        if (st.port_free) begin
          if (!out_busy) begin
            cmd.alloc = 1'b1;
            cmd.set_out = 1'b1; cmd.code = tnme_pkg::ST_OK; state_next = S_OUT;
          end
        end else if (st.port_last) begin
          if (!out_busy) begin
            cmd.set_out = 1'b1; cmd.code = tnme_pkg::ST_NO_RES; state_next = S_OUT;
          end
        end else begin
          cmd.port_rd = 1'b1;
        end
      end
      S_SWEEP: begin
        cmd.slot_rd = 1'b1;
        state_next = S_FREE;
      end
      S_FREE: begin
        cmd.sweep_eval = 1'b1;
        cmd.free_wr = 1'b1;
        state_next = S_SWEEP_END;
      end
      S_SWEEP_END: begin
        if (st.slot_last) begin
          if (!out_busy) begin
            cmd.set_out = 1'b1; cmd.code = tnme_pkg::ST_TICK; state_next = S_OUT;
          end
        end else begin
          cmd.step_scan = 1'b1;
          state_next = S_SWEEP;
        end
      end
      S_OUT: begin
        out_full_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_full <= 1'b0;
      last_rd <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
      last_rd <= last_rd_next;
    end
  end
endmodule
`default_nettype wire

FILE: src/tcp_nat_mapping_engine_core.sv
// Top level of the TCP NAPT mapping engine.
//
// channel   dir  handshake                 contents
// s_axis    in   s_axis_tvalid/tready      tuser: kind; tdata: header fields
// m_axis    out  m_axis_tvalid/tready      tdata: status and translated header
// cfg       in   cfg_we                    cfg_index selects register, cfg_data value
//
// A packet is looked up by reading all 64 slots through one memory read port,
// plus one port bitmap entry read per tried port on an allocation (up to 1024).
// A bad direction or non-TCP beat skips the lookup.
// A tick sweeps every slot in turn through S_SWEEP, S_FREE and S_SWEEP_END.
// After reset the port bitmap is cleared one entry per cycle with
// s_axis_tready low; slot valid bits clear at once; a sweep frees ports per removed slot.
// A result waits in the output register while the next beat is taken and worked on;
// that beat stalls only when its own result is ready and the register is still held.
`default_nettype none
module tcp_nat_mapping_engine_core (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: direction, protocol, src_ip, dst_ip, src_port, dst_port, tcp_flags,
  //        seq_number, ack_number (low bit up), zero-padded
  input  wire logic [183:0] s_axis_tdata,
  input  wire logic s_axis_tuser,  // kind
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tdata: status, out_src_ip, out_dst_ip, out_src_port, out_dst_port,
  //        removed_count (low bit up), zero-padded
  output logic [111:0] m_axis_tdata,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  tnme_pkg::item_t in_item;
  tnme_pkg::cmd_t cmd;
  tnme_pkg::stat_t st;
  logic [2:0] res_status;
  logic [31:0] res_src_ip, res_dst_ip;
  logic [15:0] res_src_port, res_dst_port;
  logic [6:0] res_removed;

  assign in_item = '{kind: s_axis_tuser, direction: s_axis_tdata[1:0],
    protocol: s_axis_tdata[9:2], src_ip: s_axis_tdata[41:10], dst_ip: s_axis_tdata[73:42],
    src_port: s_axis_tdata[89:74], dst_port: s_axis_tdata[105:90],
    tcp_flags: s_axis_tdata[113:106], seq_number: s_axis_tdata[145:114],
    ack_number: s_axis_tdata[177:146]};

  assign m_axis_tdata = {6'd0, res_removed, res_dst_port, res_src_port, res_dst_ip,
    res_src_ip, res_status};

  tnme_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .st(st), .cmd(cmd)
  );

  tnme_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_item(in_item), .cmd(cmd), .st(st), .res_status(res_status),
    .res_src_ip(res_src_ip), .res_dst_ip(res_dst_ip), .res_src_port(res_src_port),
    .res_dst_port(res_dst_port), .res_removed(res_removed)
  );
endmodule
`default_nettype wire
